// ===== design/table_driven_light_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Lamp sequencer assertion macros
// Shared assertion forms for the checker; clock and reset come from the scope.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_LIGHT_SEQUENCER_DEFINES_SVH
`define TABLE_DRIVEN_LIGHT_SEQUENCER_DEFINES_SVH

// Condition and property in the same cycle.
`define TDLS_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("lamp sequencer check failed");

// Property in the cycle after the condition.
`define TDLS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("lamp sequencer check failed");

// Property in the cycle after the condition, also checked through reset.
`define TDLS_ASSERT_RESET(label, cond, prop) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error("lamp sequencer check failed");

`endif

// ===== design/tdls_pkg.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer package
// Sizes, command and state codes, and the structs shared by the modules.
// ----------------------------------------------------------------------------
package tdls_pkg;

   localparam int MAX_STATES    = 16;
   localparam int DURATION_BITS = 24;
   localparam int ADDR_W        = $clog2(MAX_STATES);
   localparam int CNT_W         = $clog2(MAX_STATES + 1);
   localparam int IDX_W         = 4;
   localparam int ID_W          = 8;
   localparam int CMD_W         = 2;
   localparam int CFG_W         = 5;
   localparam int DUR_FIELD_W   = 24;
   localparam int OP_W          = DURATION_BITS;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_LOAD     = 2'd1,
      CMD_GO_INDEX = 2'd2,
      CMD_GO_ID    = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_EVAL,
      ST_TICK_WRAP,
      ST_LOAD,
      ST_GO_INDEX,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SRCH_NEXT,
      ST_FETCH,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic                     red;
      logic                     amber;
      logic                     green;
      logic [DURATION_BITS-1:0] duration;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_type;

   typedef struct packed {
      logic [OP_W-1:0] a;
      logic [OP_W-1:0] b;
   } op_type;

   typedef struct packed {
      logic eq;
      logic ge;
   } cmp_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [IDX_W-1:0] index;
      entry_type        entry;
   } request_type;

   typedef struct packed {
      logic             red;
      logic             amber;
      logic             green;
      logic [IDX_W-1:0] index;
      logic [ID_W-1:0]  id;
      logic             changed;
      logic             not_found;
   } result_type;

endpackage

// ===== design/tdls_table.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer entry table
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module tdls_table (
   input  logic                        clock,
   input  tdls_pkg::wr_type            wr,
   input  logic [tdls_pkg::ADDR_W-1:0] rd_addr,
   output tdls_pkg::entry_type         rd_data
);
   import tdls_pkg::*;

   entry_type mem [MAX_STATES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tdls_cmp.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer compare unit
// One equality and one magnitude compare, shared by the tick, jump and search steps.
// ----------------------------------------------------------------------------
module tdls_cmp (
   input  tdls_pkg::op_type  op,
   output tdls_pkg::cmp_type res
);
   import tdls_pkg::*;

   always_comb begin
      res.eq = (op.a == op.b);
      res.ge = (op.a >= op.b);
   end

endmodule

// ===== design/tdls_core.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer control
// Sequencer, timer and position registers, and the result register.
// ----------------------------------------------------------------------------
module tdls_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tdls_pkg::request_type       req,
   input  logic [tdls_pkg::CNT_W-1:0]  live_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tdls_pkg::result_type        rsp,
   output tdls_pkg::op_type            op,
   input  tdls_pkg::cmp_type           cmp,
   output tdls_pkg::wr_type            wr,
   output logic [tdls_pkg::ADDR_W-1:0] rd_addr,
   input  tdls_pkg::entry_type         rd_data
);
   import tdls_pkg::*;

   state_type                state_ff, state_in;
   request_type              req_ff, req_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ADDR_W-1:0]        search_ff, search_in;
   logic [DURATION_BITS-1:0] elapsed_ff, elapsed_in;
   logic                     changed_ff, changed_in;
   logic                     missing_ff, missing_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in;

   logic                     accept;
   logic                     show_load;
   logic [DURATION_BITS-1:0] elapsed_sat;

   assign accept      = req_valid && req_ready;
   assign show_load   = (state_ff == ST_SHOW) && (!rsp_valid_ff || rsp_ready);
   assign elapsed_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + DURATION_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.cmd)
                  CMD_TICK:     state_in = ST_TICK_RD;
                  CMD_LOAD:     state_in = ST_LOAD;
                  CMD_GO_INDEX: state_in = ST_GO_INDEX;
                  CMD_GO_ID:    state_in = ST_SRCH_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK_RD:   state_in = ST_TICK_EVAL;
         ST_TICK_EVAL: state_in = cmp.ge ? ST_TICK_WRAP : ST_FETCH;
         ST_TICK_WRAP: state_in = ST_FETCH;
         ST_LOAD:      state_in = ST_FETCH;
         ST_GO_INDEX:  state_in = ST_FETCH;
         ST_SRCH_RD:   state_in = ST_SRCH_CMP;
         ST_SRCH_CMP:  state_in = cmp.eq ? ST_FETCH : ST_SRCH_NEXT;
         ST_SRCH_NEXT: state_in = cmp.ge ? ST_FETCH : ST_SRCH_RD;
         ST_FETCH:     state_in = ST_SHOW;
         ST_SHOW:      state_in = show_load ? ST_IDLE : ST_SHOW;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Compare operands, table access and handshake.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rd_addr   = pos_ff;
      wr.en     = 1'b0;
      wr.addr   = ADDR_W'(req_ff.index);
      wr.data   = req_ff.entry;
      op.a      = '0;
      op.b      = '0;
      unique case (state_ff)
         ST_TICK_EVAL: begin
            op.a = OP_W'(elapsed_sat);
            op.b = OP_W'(rd_data.duration);
         end
         ST_TICK_WRAP: begin
            op.a = OP_W'(pos_ff) + OP_W'(1);
            op.b = OP_W'(live_count);
         end
         ST_LOAD: begin
            wr.en = (32'(req_ff.index) < MAX_STATES);
         end
         ST_GO_INDEX: begin
            op.a = OP_W'(req_ff.index);
            op.b = OP_W'(live_count);
         end
         ST_SRCH_RD: begin
            rd_addr = search_ff;
         end
         ST_SRCH_CMP: begin
            rd_addr = search_ff;
            op.a    = OP_W'(rd_data.id);
            op.b    = OP_W'(req_ff.entry.id);
         end
         ST_SRCH_NEXT: begin
            rd_addr = search_ff;
            op.a    = OP_W'(search_ff) + OP_W'(1);
            op.b    = OP_W'(live_count);
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      req_in       = req_ff;
      pos_in       = pos_ff;
      search_in    = search_ff;
      elapsed_in   = elapsed_ff;
      changed_in   = changed_ff;
      missing_in   = missing_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req;
               search_in  = '0;
               missing_in = 1'b0;
               changed_in = (req.cmd == CMD_GO_INDEX) || (req.cmd == CMD_GO_ID);
               if ((req.cmd == CMD_GO_INDEX) || (req.cmd == CMD_GO_ID)) begin
                  elapsed_in = '0;
               end
            end
         end
         ST_TICK_EVAL: begin
            if (cmp.ge) begin
               elapsed_in = '0;
               changed_in = 1'b1;
            end else begin
               elapsed_in = elapsed_sat;
            end
         end
         ST_TICK_WRAP: begin
            pos_in = cmp.ge ? '0 : pos_ff + ADDR_W'(1);
         end
         ST_GO_INDEX: begin
            missing_in = cmp.ge;
            pos_in     = cmp.ge ? '0 : ADDR_W'(req_ff.index);
         end
         ST_SRCH_CMP: begin
            if (cmp.eq) begin
               pos_in = search_ff;
            end
         end
         ST_SRCH_NEXT: begin
            if (cmp.ge) begin
               pos_in     = '0;
               missing_in = 1'b1;
            end else begin
               search_in = search_ff + ADDR_W'(1);
            end
         end
         ST_SHOW: begin
            if (show_load) begin
               rsp_valid_in     = 1'b1;
               rsp_in.red       = rd_data.red;
               rsp_in.amber     = rd_data.amber;
               rsp_in.green     = rd_data.green;
               rsp_in.index     = IDX_W'(pos_ff);
               rsp_in.id        = rd_data.id;
               rsp_in.changed   = changed_ff;
               rsp_in.not_found = missing_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      search_ff  <= search_in;
      changed_ff <= changed_in;
      missing_ff <= missing_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/table_driven_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// Table-driven light sequencer
// Timed lamp sequencer stepping through a loadable table of entries.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              contents
//   req      in         req_tvalid/req_tready  command in tuser, entry fields in tdata
//   rsp      out        rsp_tvalid/rsp_tready  lamps, current entry, flags in tdata
//   csr      in         csr_valid/csr_ready    state_count
//
// After acceptance each item runs its own states, then fetch and show: load writes the
// table, go to index checks the index, tick compares the timer and may wrap, and go to
// id reads and compares entry by entry until a match or the end of the live table.
// One item is in work at a time.
// Reset clears position, timer and state_count (to 1); the table is not cleared.
// A result waiting on rsp_tready does not stop the next item from being taken.
// ----------------------------------------------------------------------------
module table_driven_light_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, entry_id, entry_red, entry_amber, entry_green, entry_duration
   input  logic [tdls_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [tdls_pkg::CMD_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // lamp_red, lamp_amber, lamp_green, current_index, current_id, changed, not_found
   output logic [tdls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tdls_pkg::CFG_W-1:0]      csr_data
);
   import tdls_pkg::*;

   logic [CFG_W-1:0]  state_count_ff, state_count_in;
   logic [CNT_W-1:0]  live_count;
   request_type       req;
   result_type        rsp;
   op_type            op;
   cmp_type           cmp;
   wr_type            wr;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   assign csr_ready      = 1'b1;
   assign state_count_in = (csr_valid && csr_ready) ? csr_data : state_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff <= CFG_W'(1);
      end else begin
         state_count_ff <= state_count_in;
      end
   end

   // A count of zero acts as one, and counts above the table size are clipped.
   always_comb begin
      priority if (state_count_ff == '0) begin
         live_count = CNT_W'(1);
      end else if (32'(state_count_ff) > MAX_STATES) begin
         live_count = CNT_W'(MAX_STATES);
      end else begin
         live_count = CNT_W'(state_count_ff);
      end
   end

   always_comb begin
      req.cmd            = cmd_type'(req_tuser);
      req.index          = req_tdata[3:0];
      req.entry.id       = req_tdata[11:4];
      req.entry.red      = req_tdata[12];
      req.entry.amber    = req_tdata[13];
      req.entry.green    = req_tdata[14];
      req.entry.duration = DURATION_BITS'(req_tdata[15 +: DUR_FIELD_W]);
   end

   assign rsp_tdata = RSP_DATA_W'({rsp.not_found, rsp.changed, rsp.id, rsp.index,
                                   rsp.green, rsp.amber, rsp.red});

   tdls_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .live_count (live_count),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp),
      .op         (op),
      .cmp        (cmp),
      .wr         (wr),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   tdls_cmp u_cmp (
      .op  (op),
      .res (cmp)
   );

   tdls_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== design/tdls_checker.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer checker
// Port-level checks on the sequencer, attached by bind.
// ----------------------------------------------------------------------------
`include "table_driven_light_sequencer_defines.svh"

module tdls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tdls_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tdls_pkg::*;

   // A waiting result is held until it is taken.
   `TDLS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // The block works on one item at a time.
   `TDLS_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // An invalid jump target always lands on entry 0 and counts as a change.
   `TDLS_ASSERT_SAME(a_missing_changes, rsp_tvalid && rsp_tdata[16], rsp_tdata[15])
   `TDLS_ASSERT_SAME(a_missing_entry0, rsp_tvalid && rsp_tdata[16], rsp_tdata[6:3] == 4'd0)
   // No result is shown straight after reset.
   `TDLS_ASSERT_RESET(a_reset_quiet, reset, !rsp_tvalid)

endmodule

bind table_driven_light_sequencer tdls_checker u_tdls_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Lamp sequencer testbench
// Loads the lamp table, then runs directed and random tick, load and jump
// items under several table lengths. Each result is checked field by field
// against a behavioral model of the sequencer kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import tdls_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // entry_index, entry_id, entry_red, entry_amber, entry_green, entry_duration
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // command
   logic [CMD_W-1:0]      req_tuser = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // lamp_red, lamp_amber, lamp_green, current_index, current_id, changed, not_found
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;

   // Bench copy of the sequencer state.
   entry_type             lamp_table [MAX_STATES];
   logic [IDX_W-1:0]      cur_pos = '0;
   int unsigned           ticks_elapsed = 0;
   logic [CFG_W-1:0]      seq_count = 5'd1;

   request_type           item_q [$];
   result_type            lamp_expect_q [$];
   request_type           item_shown;
   int                    mismatch_count = 0;
   int                    req_sent = 0;
   int                    rsp_got = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;

   table_driven_light_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic result_type predict_lamps(request_type it);
      int unsigned span;
      int unsigned nxt;
      bit          hit;
      result_type  r;
      // Out-of-range lengths are clamped to one entry or to the full table.
      if (seq_count == 0) span = 1;
      else if (seq_count > MAX_STATES) span = MAX_STATES;
      else span = 32'(seq_count);
      r.changed = 1'b0;
      r.not_found = 1'b0;
      case (it.cmd)
         CMD_TICK: begin
            if (ticks_elapsed < (32'd1 << DURATION_BITS) - 1) ticks_elapsed++;
            if (ticks_elapsed >= lamp_table[cur_pos].duration) begin
               nxt = cur_pos + 1;
               if (nxt >= span) nxt = 0;
               cur_pos = IDX_W'(nxt);
               ticks_elapsed = 0;
               r.changed = 1'b1;
            end
         end
         CMD_LOAD: begin
            lamp_table[it.index] = it.entry;
         end
         CMD_GO_INDEX: begin
            if (it.index < span) begin
               cur_pos = it.index;
            end else begin
               cur_pos = '0;
               r.not_found = 1'b1;
            end
            ticks_elapsed = 0;
            r.changed = 1'b1;
         end
         default: begin
            hit = 1'b0;
            nxt = 0;
            for (int i = 0; i < span && !hit; i++) begin
               if (lamp_table[i].id == it.entry.id) begin
                  hit = 1'b1;
                  nxt = i;
               end
            end
            cur_pos = IDX_W'(nxt);
            r.not_found = !hit;
            ticks_elapsed = 0;
            r.changed = 1'b1;
         end
      endcase
      r.red = lamp_table[cur_pos].red;
      r.amber = lamp_table[cur_pos].amber;
      r.green = lamp_table[cur_pos].green;
      r.index = cur_pos;
      r.id = lamp_table[cur_pos].id;
      return r;
   endfunction

   function automatic request_type make_item(cmd_type cmd, int unsigned index,
                                             int unsigned id, bit [2:0] lamps,
                                             int unsigned duration);
      request_type it;
      it.cmd = cmd;
      it.index = IDX_W'(index);
      it.entry.id = ID_W'(id);
      {it.entry.red, it.entry.amber, it.entry.green} = lamps;
      it.entry.duration = DURATION_BITS'(duration);
      return it;
   endfunction

   function automatic request_type random_item();
      request_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) it.cmd = CMD_TICK;
      else if (pick < 70) it.cmd = CMD_LOAD;
      else if (pick < 85) it.cmd = CMD_GO_INDEX;
      else it.cmd = CMD_GO_ID;
      it.index = IDX_W'($urandom_range(0, MAX_STATES - 1));
      // Half the ids come from a small pool so that id searches often hit.
      if ($urandom_range(0, 1) == 1) it.entry.id = 8'($urandom_range(8'h10, 8'h1F));
      else it.entry.id = 8'($urandom);
      it.entry.red = 1'($urandom);
      it.entry.amber = 1'($urandom);
      it.entry.green = 1'($urandom);
      // Mostly short durations so that ticks actually advance the sequence.
      if ($urandom_range(0, 3) == 0) it.entry.duration = 24'($urandom);
      else it.entry.duration = 24'($urandom_range(0, 4));
      return it;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lamp_expect_q.push_back(predict_lamps(item_shown));
            req_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (item_q.size() != 0 &&
                ((req_sent >= 700 && req_sent < 1000) || $urandom_range(0, 99) >= 7)) begin
               item_shown = item_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item_shown.cmd;
               req_tdata <= {1'b0, item_shown.entry.duration, item_shown.entry.green,
                             item_shown.entry.amber, item_shown.entry.red,
                             item_shown.entry.id, item_shown.index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got++;
            if (lamp_expect_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = lamp_expect_q.pop_front();
               check_field("lamp_red", want.red, rsp_tdata[0]);
               check_field("lamp_amber", want.amber, rsp_tdata[1]);
               check_field("lamp_green", want.green, rsp_tdata[2]);
               check_field("current_index", want.index, rsp_tdata[6:3]);
               check_field("current_id", want.id, rsp_tdata[14:7]);
               check_field("changed", want.changed, rsp_tdata[15]);
               check_field("not_found", want.not_found, rsp_tdata[16]);
            end
         end
         // One long hold-off lets the sequencer back up into its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_got == 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (rsp_got >= 1200 && rsp_got < 1500) || $urandom_range(0, 99) >= 7;
         end
      end
   end

   // Waits until every queued item has been taken and answered, then lets the
   // longest search time pass.
   task automatic settle();
      int guard;
      guard = 0;
      while ((item_q.size() != 0 || req_tvalid || lamp_expect_q.size() != 0) &&
             guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_count(logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      seq_count = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) item_q.push_back(random_item());
   endtask

   initial begin
      logic [CFG_W-1:0] phase_counts [8];
      phase_counts = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd16, 5'd7,
                       5'($urandom_range(1, 16)), 5'($urandom_range(0, 31))};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_count(5'd16);
      // Entry 0 goes first so that the current entry is always a loaded one.
      // Entry 9 repeats the id of entry 3 to check first-match searching.
      for (int i = 0; i < MAX_STATES; i++) begin
         if (i == 0) item_q.push_back(make_item(CMD_LOAD, 0, 8'h00, 3'b000, 0));
         else if (i == 1) item_q.push_back(make_item(CMD_LOAD, 1, 8'h11, 3'b100, 1));
         else if (i == 9) item_q.push_back(make_item(CMD_LOAD, 9, 8'h13, 3'b001, 2));
         else if (i == 15) item_q.push_back(make_item(CMD_LOAD, 15, 8'hFF, 3'b111, 24'hFFFFFF));
         else item_q.push_back(make_item(CMD_LOAD, i, 8'h10 + i, i[2:0], i % 3 + 1));
      end
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_INDEX, 15, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_INDEX, 15, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_ID, 0, 8'hFF, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_ID, 0, 8'h13, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_ID, 0, 8'hAB, 3'b000, 0));
      // Reloading the current entry shows the new lamps and timing at once.
      item_q.push_back(make_item(CMD_LOAD, 0, 8'h00, 3'b101, 2));
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_INDEX, 12, 0, 3'b000, 0));
      settle();

      // Shrinking the table below the position makes the next advance wrap.
      write_count(5'd4);
      item_q.push_back(make_item(CMD_TICK, 0, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_INDEX, 9, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_ID, 0, 8'h1C, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_INDEX, 3, 0, 3'b000, 0));
      item_q.push_back(make_item(CMD_GO_ID, 0, 8'h13, 3'b000, 0));
      queue_random(216);
      settle();

      foreach (phase_counts[p]) begin
         write_count(phase_counts[p]);
         queue_random(216);
         settle();
      end

      if (lamp_expect_q.size() != 0) begin
         $display("%0t: %0d results expected, none arrived", $time, lamp_expect_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
